[rtl/core/rde_pkg.sv]
// ----------------------------------------------------------------------------
// rde_pkg
// Shared constants and controller/datapath interface types for the radix
// digit emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package rde_pkg;

   localparam int MAX_SYMBOLS = 16;
   localparam int SYM_W       = 8;
   localparam int DIGIT_W     = $clog2(MAX_SYMBOLS);
   localparam int RADIX_W     = DIGIT_W + 1;
   localparam int VALUE_W     = 32;
   localparam int STACK_DEPTH = VALUE_W;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int BITS_PER_CYCLE = 8;
   localparam int CHUNKS      = VALUE_W / BITS_PER_CYCLE;
   localparam int CHUNK_W     = $clog2(CHUNKS);
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [SYM_W-1:0] MINUS_SYMBOL   = 8'h2D;
   localparam logic [SYM_W-1:0] PLUS_SYMBOL    = 8'h2B;
   localparam logic [SYM_W-1:0] LOWEST_SYMBOL  = 8'd32;
   localparam logic [SYM_W-1:0] HIGHEST_SYMBOL = 8'd127;
   localparam logic [RADIX_W-1:0] MIN_RADIX    = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] MAX_RADIX    = RADIX_W'(MAX_SYMBOLS);

   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOLS_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX        = 2'd2;

   localparam logic [CSR_DATA_W-1:0] SYMBOLS_LOW_RESET  = 64'h3736353433323130;
   localparam logic [CSR_DATA_W-1:0] SYMBOLS_HIGH_RESET = 64'h0000000000003938;
   localparam logic [RADIX_W-1:0]    RADIX_RESET        = RADIX_W'(10);

   typedef struct packed {
      logic load;
      logic div_step;
      logic digit_end;
      logic emit_sign;
      logic emit_digit;
   } dp_cmd_type;

   typedef struct packed {
      logic table_ok;
      logic quo_zero;
      logic negative;
      logic cnt_one;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/core/rde_ctrl.sv]
// ----------------------------------------------------------------------------
// rde_ctrl
// Sequencer that accepts a request and, if the table checks out, runs the digit
// divider and then drives the sign and digit symbols out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  rde_pkg::dp_status_type stat,
   output rde_pkg::dp_cmd_type    cmd
);
   import rde_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_SIGN  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;

   always_comb begin
      state_in  = state_ff;
      chunk_in  = chunk_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            chunk_in = '0;
            state_in = stat.table_ok ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            chunk_in     = chunk_ff + CHUNK_W'(1);
            if (chunk_ff == CHUNK_W'(CHUNKS - 1)) begin
               cmd.digit_end = 1'b1;
               if (stat.quo_zero) begin
                  state_in = ST_SIGN;
               end
            end
         end
         ST_SIGN: begin
            if (!stat.negative) begin
               state_in = ST_EMIT;
            end else if (stat.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_digit = 1'b1;
               if (stat.cnt_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chunk_ff <= '0;
      end else begin
         state_ff <= state_in;
         chunk_ff <= chunk_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/rde_datapath.sv]
// ----------------------------------------------------------------------------
// rde_datapath
// Configuration registers, table check, radix divider, digit stack and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_datapath (
   input  wire                               clock,
   input  wire                               reset,
   input  wire signed [rde_pkg::VALUE_W-1:0] req_value,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [rde_pkg::SYM_W-1:0]         rsp_symbol,
   output logic                              rsp_last,
   input  wire                               csr_valid,
   input  wire  [rde_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [rde_pkg::CSR_DATA_W-1:0]    csr_data,
   input  rde_pkg::dp_cmd_type               cmd,
   output rde_pkg::dp_status_type            stat
);
   import rde_pkg::*;

   logic [CSR_DATA_W-1:0] sym_low_ff;
   logic [CSR_DATA_W-1:0] sym_high_ff;
   logic [RADIX_W-1:0]    radix_ff;
   logic                  table_ok_ff, table_ok_in;

   logic [2*CSR_DATA_W-1:0] table_bits;
   logic [SYM_W-1:0]        sym [MAX_SYMBOLS];
   logic [MAX_SYMBOLS-1:0]  in_use;

   logic [VALUE_W-1:0] raw;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic               neg_ff;
   logic [DIGIT_W-1:0] stack_ff [STACK_DEPTH];
   logic [CNT_W-1:0]   cnt_ff;

   logic               rsp_valid_ff;
   logic [SYM_W-1:0]   rsp_symbol_ff;
   logic               rsp_last_ff;
   logic               out_free;

   assign table_bits = {sym_high_ff, sym_low_ff};

   always_comb begin
      for (int k = 0; k < MAX_SYMBOLS; k++) begin
         sym[k]    = table_bits[k*SYM_W +: SYM_W];
         in_use[k] = RADIX_W'(k) < radix_ff;
      end
   end

   always_comb begin
      table_ok_in = (radix_ff >= MIN_RADIX) && (radix_ff <= MAX_RADIX);
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
         if (in_use[i]) begin
            if (sym[i] == PLUS_SYMBOL || sym[i] == MINUS_SYMBOL ||
                sym[i] < LOWEST_SYMBOL || sym[i] > HIGHEST_SYMBOL) begin
               table_ok_in = 1'b0;
            end
            for (int j = 0; j < i; j++) begin
               if (sym[j] == sym[i]) begin
                  table_ok_in = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_low_ff  <= SYMBOLS_LOW_RESET;
         sym_high_ff <= SYMBOLS_HIGH_RESET;
         radix_ff    <= RADIX_RESET;
         table_ok_ff <= 1'b0;
      end else begin
         table_ok_ff <= table_ok_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_SYMBOLS_LOW:  sym_low_ff  <= csr_data;
               CSR_SYMBOLS_HIGH: sym_high_ff <= csr_data;
               CSR_RADIX:        radix_ff    <= csr_data[RADIX_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Restoring division of the magnitude by the radix, several quotient
   // bits per cycle; the quotient shifts into the magnitude register.
   always_comb begin
      rem_in = rem_ff;
      mag_in = mag_ff;
      for (int k = 0; k < BITS_PER_CYCLE; k++) begin
         rem_in = {rem_in[RADIX_W-2:0], mag_in[VALUE_W-1]};
         mag_in = {mag_in[VALUE_W-2:0], 1'b0};
         if (rem_in >= radix_ff) begin
            rem_in    = rem_in - radix_ff;
            mag_in[0] = 1'b1;
         end
      end
   end

   assign raw = req_value;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= raw[VALUE_W-1];
         mag_ff <= raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         mag_ff <= mag_in;
         if (cmd.digit_end) begin
            rem_ff      <= '0;
            cnt_ff      <= cnt_ff + CNT_W'(1);
            stack_ff[0] <= rem_in[DIGIT_W-1:0];
            for (int k = 1; k < STACK_DEPTH; k++) begin
               stack_ff[k] <= stack_ff[k-1];
            end
         end else begin
            rem_ff <= rem_in;
         end
      end else if (cmd.emit_digit) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         for (int k = 0; k < STACK_DEPTH - 1; k++) begin
            stack_ff[k] <= stack_ff[k+1];
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_sign || cmd.emit_digit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_sign) begin
         rsp_symbol_ff <= MINUS_SYMBOL;
         rsp_last_ff   <= 1'b0;
      end else if (cmd.emit_digit) begin
         rsp_symbol_ff <= sym[stack_ff[0]];
         rsp_last_ff   <= (cnt_ff == CNT_W'(1));
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   assign stat.table_ok = table_ok_ff;
   assign stat.quo_zero = (mag_in == '0);
   assign stat.negative = neg_ff;
   assign stat.cnt_one  = (cnt_ff == CNT_W'(1));
   assign stat.out_free = out_free;

endmodule

`default_nettype wire

[rtl/core/radix_digit_emitter.sv]
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Converts a signed 32-bit value into symbol bytes in a configurable radix,
// minus sign first for a negative value and most significant digit next, with the final symbol flagged.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Contents
//  req_      in         req_valid/req_ready    value, signed 32 bits
//  rsp_      out        rsp_valid/rsp_ready    symbol byte and last flag
//  csr_      in         csr_valid/csr_ready    register index and 64-bit data
//
// A request is accepted in the idle state and the table is checked in the check
// state; the divider then runs (eight quotient bits a cycle), then the sign step,
// which emits the minus of a negative value, and then one step per digit symbol.
// Reset restores the decimal table and clears the sequencer and output.
// Stalls on rsp_ready hold the sequencer; the next request is taken as soon
// as the last symbol sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_emitter (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire signed [rde_pkg::VALUE_W-1:0] req_value,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [rde_pkg::SYM_W-1:0]         rsp_symbol,
   output logic                              rsp_last,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [rde_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [rde_pkg::CSR_DATA_W-1:0]    csr_data
);
   import rde_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type stat;

   assign csr_ready = 1'b1;

   rde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rde_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat)
   );

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit) |-> stat.out_free)
      else $error("symbol loaded while the output register is occupied");

   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.div_step, cmd.emit_sign, cmd.emit_digit}))
      else $error("conflicting datapath commands");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_valid && req_ready))
      else $error("datapath loaded without an accepted request");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_digit && stat.cnt_one) |=> (rsp_valid && rsp_last))
      else $error("final digit not flagged as last");
`endif

endmodule

`default_nettype wire
